/* rtl/lsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_pkg - shared types and constants for the largest-square core
// Grid geometry limits, field widths and the three-way minimum helper.
// ----------------------------------------------------------------------------
package lsq_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int SIDE_W = 11;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CNT_W  = 11;

   typedef logic [SIDE_W-1:0] side_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CNT_W-1:0]  count_type;

   function automatic side_type min3(side_type a, side_type b, side_type c);
      side_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

/* rtl/lsq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_req_if - grid cell request channel
// Valid/ready handshake carrying one grid cell and its last-cell mark.
// ----------------------------------------------------------------------------
interface lsq_req_if;
   logic valid;
   logic ready;
   logic cell_free;
   logic last_cell;

   modport source (output valid, output cell_free, output last_cell, input ready);
   modport sink   (input valid, input cell_free, input last_cell, output ready);
endinterface

/* rtl/lsq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_rsp_if - largest-square result channel
// Valid/ready handshake carrying the best square side and its corner.
// ----------------------------------------------------------------------------
interface lsq_rsp_if
   import lsq_pkg::*;
   ;
   logic     valid;
   logic     ready;
   side_type square_side;
   col_type  corner_col;
   row_type  corner_row;

   modport source (output valid, output square_side, output corner_col,
                   output corner_row, input ready);
   modport sink   (input valid, input square_side, input corner_col,
                   input corner_row, output ready);
endinterface

/* rtl/largest_square_of_ones_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_square_of_ones_core - streaming maximal free square finder
// Raster-order grid cells in, one best-square report per grid out.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   req_ch    in    valid/ready        cell_free, last_cell
//   rsp_ch    out   valid/ready        square_side, corner_col, corner_row
//   csr_*     in    write enable only  column_count (11 bits)
//
// One request per cycle sustained while requests are not stalled. A last
// cell retires from stage 2 into the result register or its spare. Stage 1
// reads the up side from the line buffer, stage 2 writes the new side back;
// a same-column write is forwarded. Reset is synchronous; it clears counters
// and the best square, not the line buffer. Requests stall only while a last
// cell sits in stage 2 and both result registers hold untaken results.
// ----------------------------------------------------------------------------
module largest_square_of_ones_core
   import lsq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  count_type      csr_write_data,
   lsq_req_if.sink        req_ch,
   lsq_rsp_if.source      rsp_ch
);

   // configuration
   count_type column_count_ff;
   count_type cols_eff;

   // input-side counters (position of the next request)
   col_type col_counter_ff, col_counter_in;
   row_type row_counter_ff, row_counter_in;

   // stage 1: request accepted, line buffer read in flight
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_cell_ff;
   logic     s1_last_ff;
   col_type  s1_col_ff;
   row_type  s1_row_ff;
   side_type rd_data_ff;
   logic     fwd_ff;
   side_type fwd_data_ff;

   // stage 2 running state
   side_type left_side_ff, left_side_in;
   side_type diag_side_ff, diag_side_in;
   side_type best_side_ff, best_side_in;
   col_type  best_col_ff,  best_col_in;
   row_type  best_row_ff,  best_row_in;

   // result register
   logic     out_valid_ff, out_valid_in;
   side_type out_side_ff;
   col_type  out_col_ff;
   row_type  out_row_ff;

   // spare result register, keeps the input free of the output ready
   logic     spare_valid_ff, spare_valid_in;
   side_type spare_side_ff;
   col_type  spare_col_ff;
   row_type  spare_row_ff;

   // previous-row sides
   side_type line_mem [MAX_COLS];

   logic     accept;
   logic     stall;
   logic     s2_fire;
   logic     result_load;
   logic     head_free;
   side_type up_side;
   side_type cur_side;
   logic     take_best;
   side_type new_best_side;
   col_type  new_best_col;
   row_type  new_best_row;

   // clamp column count into 1..MAX_COLS
   always_comb begin
      if (column_count_ff == '0) begin
         cols_eff = count_type'(1);
      end else if (column_count_ff > count_type'(MAX_COLS)) begin
         cols_eff = count_type'(MAX_COLS);
      end else begin
         cols_eff = column_count_ff;
      end
   end

   // a last cell cannot leave stage 2 while both result registers are occupied
   assign stall   = s1_valid_ff && s1_last_ff && spare_valid_ff;
   assign s2_fire = s1_valid_ff && !stall;
   assign req_ch.ready = !stall;
   assign accept  = req_ch.valid && req_ch.ready;

   // next position
   always_comb begin
      col_counter_in = col_counter_ff;
      row_counter_in = row_counter_ff;
      if (accept) begin
         if (req_ch.last_cell) begin
            col_counter_in = '0;
            row_counter_in = '0;
         end else if ((count_type'(col_counter_ff) + count_type'(1)) >= cols_eff) begin
            col_counter_in = '0;
            if (row_counter_ff != row_type'(MAX_ROWS - 1)) begin
               row_counter_in = row_counter_ff + row_type'(1);
            end
         end else begin
            col_counter_in = col_counter_ff + col_type'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // stage 2: dynamic-programming update
   // the up side is the line buffer read, or the write that stage 2 did to the same column in the cycle of this read
   assign up_side = fwd_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      if (s1_row_ff == '0 || s1_col_ff == '0) begin
         cur_side = side_type'(s1_cell_ff);
      end else if (s1_cell_ff) begin
         cur_side = min3(up_side, left_side_ff, diag_side_ff) + side_type'(1);
      end else begin
         cur_side = '0;
      end
   end

   assign take_best     = cur_side > best_side_ff;
   assign new_best_side = take_best ? cur_side  : best_side_ff;
   assign new_best_col  = take_best ? s1_col_ff : best_col_ff;
   assign new_best_row  = take_best ? s1_row_ff : best_row_ff;

   always_comb begin
      left_side_in = left_side_ff;
      diag_side_in = diag_side_ff;
      best_side_in = best_side_ff;
      best_col_in  = best_col_ff;
      best_row_in  = best_row_ff;
      if (s2_fire) begin
         if (s1_last_ff) begin
            // grid done: start over
            left_side_in = '0;
            diag_side_in = '0;
            best_side_in = '0;
            best_col_in  = '0;
            best_row_in  = '0;
         end else begin
            left_side_in = cur_side;
            diag_side_in = up_side;
            best_side_in = new_best_side;
            best_col_in  = new_best_col;
            best_row_in  = new_best_row;
         end
      end
   end

   // result queue of two: head drives the port, spare catches a result
   // that arrives while the head waits
   assign result_load = s2_fire && s1_last_ff;
   assign head_free   = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      if (head_free) begin
         if (spare_valid_ff) begin
            out_valid_in   = 1'b1;
            spare_valid_in = result_load;
         end else begin
            out_valid_in   = result_load;
            spare_valid_in = 1'b0;
         end
      end else if (result_load) begin
         spare_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= count_type'(MAX_COLS);
         col_counter_ff  <= '0;
         row_counter_ff  <= '0;
         s1_valid_ff     <= 1'b0;
         left_side_ff    <= '0;
         diag_side_ff    <= '0;
         best_side_ff    <= '0;
         best_col_ff     <= '0;
         best_row_ff     <= '0;
         out_valid_ff    <= 1'b0;
         spare_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            column_count_ff <= csr_write_data;
         end
         col_counter_ff <= col_counter_in;
         row_counter_ff <= row_counter_in;
         s1_valid_ff    <= s1_valid_in;
         left_side_ff   <= left_side_in;
         diag_side_ff   <= diag_side_in;
         best_side_ff   <= best_side_in;
         best_col_ff    <= best_col_in;
         best_row_ff    <= best_row_in;
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   // stage 1 payload and forwarding capture
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff  <= req_ch.cell_free;
         s1_last_ff  <= req_ch.last_cell;
         s1_col_ff   <= col_counter_ff;
         s1_row_ff   <= row_counter_ff;
         fwd_ff      <= s1_valid_ff && (s1_col_ff == col_counter_ff);
         fwd_data_ff <= cur_side;
      end
   end

   // line buffer: read on accept, write on stage 2 retire
   always_ff @(posedge clock) begin
      if (s2_fire) begin
         line_mem[s1_col_ff] <= cur_side;
      end
      if (accept) begin
         rd_data_ff <= line_mem[col_counter_ff];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (head_free) begin
         if (spare_valid_ff) begin
            out_side_ff <= spare_side_ff;
            out_col_ff  <= spare_col_ff;
            out_row_ff  <= spare_row_ff;
         end else if (result_load) begin
            out_side_ff <= new_best_side;
            out_col_ff  <= new_best_col;
            out_row_ff  <= new_best_row;
         end
      end
      if (result_load && (spare_valid_ff || !head_free)) begin
         spare_side_ff <= new_best_side;
         spare_col_ff  <= new_best_col;
         spare_row_ff  <= new_best_row;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.square_side = out_side_ff;
   assign rsp_ch.corner_col  = out_col_ff;
   assign rsp_ch.corner_row  = out_row_ff;

`ifndef SYNTH
   // a stalled last cell stays in stage 2
   assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff && s1_last_ff)
      else $error("stalled last cell lost from stage 2");

   // a retiring last cell leaves the result register valid
   assert property (@(posedge clock) disable iff (reset)
      s2_fire && s1_last_ff |=> out_valid_ff)
      else $error("last cell retired without a result");

   // a finished grid leaves a clean slate
   assert property (@(posedge clock) disable iff (reset)
      s2_fire && s1_last_ff |=> best_side_ff == '0 && left_side_ff == '0
                                && diag_side_ff == '0)
      else $error("grid state not cleared after last cell");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for largest_square_of_ones_core
// Streams binary grids through the request channel under random sender
// bursts and receiver stalls. A cycle-free predictor computes the best square
// of every grid, and each result is matched field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   import lsq_pkg::*;

   // Best square of one grid: side and bottom-right corner.
   typedef struct {
      side_type side;
      col_type  col;
      row_type  row;
   } square_type;

   // Tracks the grid the way the core does: line buffer of the previous row,
   // left and up-left sides, raster position and the best square so far.
   // take_cell() runs once per accepted request; a last cell queues the
   // square that the core owes us.
   class square_finder_type;
      side_type   line_sides [MAX_COLS];
      side_type   left_sz;
      side_type   diag_sz;
      int         col_pos;
      int         row_pos;
      square_type best;
      count_type  col_setting;
      square_type awaited_squares [$];
      int         mismatch_count;

      function new();
         foreach (line_sides[i]) line_sides[i] = '0;
         col_setting    = count_type'(MAX_COLS);
         mismatch_count = 0;
         clear_grid();
      endfunction

      function void clear_grid();
         left_sz  = '0;
         diag_sz  = '0;
         col_pos  = 0;
         row_pos  = 0;
         best     = '{side: '0, col: '0, row: '0};
      endfunction

      function void set_columns(count_type value);
         col_setting = value;
      endfunction

      function void take_cell(bit free_bit, bit last);
         int       cols;
         side_type up_sz;
         side_type low_sz;
         side_type cell_sz;
         cols = col_setting;
         if (cols == 0) cols = 1;
         if (cols > MAX_COLS) cols = MAX_COLS;
         if (col_pos >= MAX_COLS) col_pos = 0;

         up_sz = line_sides[col_pos];
         if (row_pos == 0 || col_pos == 0) begin
            cell_sz = side_type'(free_bit);
         end else if (free_bit) begin
            low_sz  = (up_sz < left_sz) ? up_sz : left_sz;
            low_sz  = (low_sz < diag_sz) ? low_sz : diag_sz;
            cell_sz = low_sz + side_type'(1);
         end else begin
            cell_sz = '0;
         end

         diag_sz = up_sz;
         left_sz = cell_sz;
         line_sides[col_pos] = cell_sz;

         // strictly larger only: first square in raster order wins
         if (cell_sz > best.side) begin
            best.side = cell_sz;
            best.col  = col_type'(col_pos);
            best.row  = row_type'(row_pos);
         end

         if (last) begin
            awaited_squares.push_back(best);
            clear_grid();
            return;
         end

         if (col_pos + 1 >= cols) begin
            col_pos = 0;
            if (row_pos + 1 < MAX_ROWS) row_pos++;
         end else begin
            col_pos++;
         end
      endfunction

      function void match_square(side_type side, col_type col, row_type row);
         square_type want;
         if (awaited_squares.size() == 0) begin
            $error("unexpected result: side %0d col %0d row %0d", side, col, row);
            mismatch_count++;
            return;
         end
         want = awaited_squares.pop_front();
         if (side !== want.side) begin
            $error("square_side: expected %0d, actual %0d", want.side, side);
            mismatch_count++;
         end
         if (col !== want.col) begin
            $error("corner_col: expected %0d, actual %0d", want.col, col);
            mismatch_count++;
         end
         if (row !== want.row) begin
            $error("corner_row: expected %0d, actual %0d", want.row, row);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return awaited_squares.size();
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      csr_write_enable;
   count_type csr_write_data;

   lsq_req_if req_ch ();
   lsq_rsp_if rsp_ch ();

   square_finder_type finder;

   // sender burst bookkeeping and the long receiver hold-off trigger
   int   burst_left = 0;
   int   hold_off_count = 0;
   int   current_cols = MAX_COLS;

   largest_square_of_ones_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   // 12 ns period, starts low so the first rising edge is at 6 ns
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offer one request. The sender runs in bursts; when a burst is used up
   // it may drop valid for a random gap before the next one. Valid is only
   // lowered in a step where it is not also raised.
   task automatic send_cell(input bit free_bit, input bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.cell_free <= free_bit;
      req_ch.last_cell <= last;
      // values read right after the edge are the ones the core sampled
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      finder.take_cell(free_bit, last);
   endtask

   // Random grid of n_cells in raster order; cells before free_from are
   // blocked, later ones free with probability free_pct. Last cell marked.
   task automatic send_grid(input int n_cells, input int free_pct, input int free_from);
      bit free_bit;
      for (int i = 0; i < n_cells; i++) begin
         free_bit = (i >= free_from) && ($urandom_range(1, 100) <= free_pct);
         send_cell(free_bit, i == n_cells - 1);
      end
   endtask

   // Fixed grid, bits[0] goes first.
   task automatic send_bits(input logic [31:0] bits, input int n_cells);
      for (int i = 0; i < n_cells; i++)
         send_cell(bits[i], i == n_cells - 1);
   endtask

   // Stop offering, wait out every owed result, then let the pipeline drain.
   task automatic wait_for_squares();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (finder.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Column count only changes with the core idle, between grids.
   task automatic write_column_count(input int value);
      wait_for_squares();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count_type'(value);
      @(posedge clock);
      finder.set_columns(count_type'(value));
      csr_write_enable <= 1'b0;
      current_cols = (value == 0) ? 1 : (value > MAX_COLS) ? MAX_COLS : value;
   endtask

   // Result sink: every accepted result goes to the predictor.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         finder.match_square(rsp_ch.square_side, rsp_ch.corner_col, rsp_ch.corner_row);
   end

   // Receiver ready pattern: windows of always-ready, coin-flip, one in four
   // and mostly-stalled. A new hold-off request drops ready before the window goes on.
   initial begin
      int mode;
      int window;
      int tick;
      int holds_seen;
      rsp_ch.ready = 1'b0;
      tick = 0;
      holds_seen = 0;
      forever begin
         mode   = $urandom_range(0, 3);
         window = $urandom_range(20, 120);
         repeat (window) begin
            @(posedge clock);
            if (hold_off_count != holds_seen) begin
               holds_seen   = hold_off_count;
               rsp_ch.ready <= 1'b0;
               repeat (300) @(posedge clock);
            end
            tick++;
            case (mode)
               0: begin
                  rsp_ch.ready <= 1'b1;
               end
               1: begin
                  rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               end
               2: begin
                  rsp_ch.ready <= (tick % 4 == 0);
               end
               default: begin
                  rsp_ch.ready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   // Stimulus: directed grids, random grids with a pressure phase, then
   // oversized column counts.
   initial begin
      int grids;
      int random_items;
      int cols;
      int rows;
      int n_cells;
      int pct;

      finder           = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.cell_free = 1'b0;
      req_ch.last_cell = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset width (1024 columns), row 0 only: side 1 at column 1
      send_bits(32'b10110, 5);
      // zero column count acts as one column: each cell is its own row
      write_column_count(0);
      send_bits(32'b100, 3);
      // no free cell: all-zero result
      write_column_count(3);
      send_bits(32'h0, 4);
      // full 3x3: side 3 at the far corner
      send_bits(32'h1FF, 9);
      // two equal squares: the earlier one stays
      write_column_count(2);
      send_bits(32'h3F, 6);
      current_cols = 2;

      grids        = 0;
      random_items = 0;
      while (random_items < 340 || grids < 13) begin
         if (grids == 12) begin
            // receiver holds off while one-cell grids keep coming, so the
            // result registers fill and the core stalls its input
            wait_for_squares();
            hold_off_count++;
            burst_left = 8;
            repeat (6) send_cell(1'($urandom_range(0, 1)), 1'b1);
            random_items += 6;
            // sender pause until everything owed has come back
            wait_for_squares();
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0: cols = 0;
               1: cols = $urandom_range(9, 40);
               default: cols = $urandom_range(1, 8);
            endcase
            write_column_count(cols);
         end
         rows    = $urandom_range(1, 6);
         n_cells = (rows - 1) * current_cols + $urandom_range(1, current_cols);
         case ($urandom_range(0, 3))
            0: pct = 50;
            1: pct = 80;
            2: pct = 95;
            default: pct = 100;
         endcase
         send_grid(n_cells, pct, 0);
         random_items += n_cells;
         grids++;
      end

      // oversized count saturates to full width, short row-0 grid
      write_column_count(2047);
      send_grid($urandom_range(2, 20), 97, 0);
      // just above full width, short row-0 grid
      write_column_count(MAX_COLS + 1);
      send_grid($urandom_range(2, 20), 60, 0);

      wait_for_squares();
      repeat (8) @(posedge clock);
      if (finder.mismatch_count == 0) begin
         $display("largest_square_of_ones_core verification clean");
      end else begin
         $display("largest_square_of_ones_core verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("largest_square_of_ones_core verification failed");
      $finish;
   end

endmodule
